FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define SFC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");

// Condition that must never be seen outside reset.
`define SFC_NEVER(label, clk, rst_n, cond) \
	`SFC_ASSERT(label, clk, rst_n, !(cond))

`endif

FILE: design/sfc_pkg.sv
`timescale 1ns / 1ps
package sfc_pkg;

	// Frame and arithmetic sizes.
	localparam int MAX_STRIPS  = 1024;
	localparam int AMP_BITS    = 16;
	localparam int FRAC_BITS   = 8;
	localparam int POS_W       = $clog2(MAX_STRIPS);
	localparam int SIZE_W      = POS_W + 1;
	localparam int SQ_W        = 2 * POS_W;
	localparam int WT_W        = AMP_BITS + 1;
	localparam int P1_W        = POS_W + WT_W;
	localparam int P2_W        = SQ_W + WT_W;
	localparam int CNT_W       = 11;
	localparam int W_W         = 27;
	localparam int S1_W        = 37;
	localparam int S2_W        = 47;
	localparam int SER_W       = 16;
	localparam int CEN_W       = 18;
	localparam int SPR_W       = 26;
	localparam int CFG_W       = 16;
	localparam int QUEUE_DEPTH = 4;

	// Back end datapath sizes.
	localparam int PROD_W     = S2_W + W_W;
	localparam int DIV_W      = PROD_W + FRAC_BITS;
	localparam int CEN_NUM_W  = S1_W + FRAC_BITS + 1;
	localparam int CEN_FULL_W = SIZE_W + FRAC_BITS;
	localparam int ML_W       = S1_W;
	localparam int STEP_W     = $clog2(DIV_W + 1);

	// Spread of a single strip cluster: 1/sqrt(12), rounded.
	localparam logic [63:0] INV_SQRT12_Q32 = 64'd1239850262;
	localparam logic [63:0] SPREAD_SINGLE =
		((INV_SQRT12_Q32 << FRAC_BITS) + 64'h0000_0000_8000_0000) >> 32;

	typedef enum logic [0:0] {
		CFG_THRESHOLD  = 1'b0,
		CFG_LAYER_KIND = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CEN,
		BK_MUL_A,
		BK_MUL_B,
		BK_DIFF,
		BK_DIV1,
		BK_DIV2,
		BK_OUT
	} back_state_t;

	// One closed cluster, as handed from the front to the back.
	typedef struct packed {
		logic [W_W-1:0]    weight;
		logic [S1_W-1:0]   s1;
		logic [S2_W-1:0]   s2;
		logic [CNT_W-1:0]  count;
		logic [SIZE_W-1:0] size;
		logic [SER_W-1:0]  serial;
		logic              kind;
		logic              last;
	} cluster_rec_t;

	// Queue fill status seen by the front and the back.
	typedef struct packed {
		logic room2;
		logic not_empty;
	} queue_stat_t;

endpackage

FILE: design/sfc_ifs.sv
`timescale 1ns / 1ps
interface strip_in_if;
	import sfc_pkg::*;
	logic                valid;
	logic                ready;
	logic [AMP_BITS-1:0] strip_amplitude;
	logic                frame_end;

	modport source (output valid, output strip_amplitude, output frame_end, input ready);
	modport sink (input valid, input strip_amplitude, input frame_end, output ready);
endinterface

interface cluster_out_if;
	import sfc_pkg::*;
	logic              valid;
	logic              ready;
	logic [CEN_W-1:0]  centroid_q8;
	logic [W_W-1:0]    total_half_units;
	logic [SPR_W-1:0]  spread_q8;
	logic [CNT_W-1:0]  member_count;
	logic [SER_W-1:0]  cluster_serial;
	logic              cluster_kind;
	logic              run_last;

	modport source (output valid, output centroid_q8, output total_half_units,
		output spread_q8, output member_count, output cluster_serial,
		output cluster_kind, output run_last, input ready);
	modport sink (input valid, input centroid_q8, input total_half_units,
		input spread_q8, input member_count, input cluster_serial,
		input cluster_kind, input run_last, output ready);
endinterface

FILE: design/sfc_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  sfc_pkg::cfg_reg_t             cfg_index,
	input  logic [sfc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sfc_pkg::AMP_BITS-1:0]  amp,
	input  logic                          frame_end,
	input  sfc_pkg::queue_stat_t          qstat,
	output logic                          push,
	output sfc_pkg::cluster_rec_t         push_rec
);
	import sfc_pkg::*;

	logic [AMP_BITS-1:0] thr_q;
	logic                kind_q;
	logic [POS_W-1:0]    pos_q;
	logic [SQ_W-1:0]     sq_q;
	logic [WT_W-1:0]     prior_q;
	logic [P1_W-1:0]     p1_q;
	logic [P2_W-1:0]     p2_q;
	logic                fall_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [W_W-1:0]      w_q;
	logic [S1_W-1:0]     s1_q;
	logic [S2_W-1:0]     s2_q;
	logic [SER_W-1:0]    lower_q, upper_q;
	logic                pend_q;
	cluster_rec_t        pend_rec_q;

	logic                accept, below, has_open, rising_ok, split, last;
	logic                emit0, emit1;
	logic [WT_W-1:0]     w2, half;
	logic [P1_W-1:0]     m1;
	logic [P2_W-1:0]     m2;
	logic [CNT_W-1:0]    n_cnt;
	logic [W_W-1:0]      n_w;
	logic [S1_W-1:0]     n_s1;
	logic [S2_W-1:0]     n_s2;
	logic [SER_W-1:0]    ser_base;
	cluster_rec_t        rec0, rec1;

	assign in_ready = !pend_q && qstat.room2;
	assign accept   = in_valid && in_ready;

	// Strip weight and its moment contributions.
	assign w2   = {amp, 1'b0};
	assign m1   = P1_W'(pos_q) * P1_W'(w2);
	assign m2   = P2_W'(sq_q) * P2_W'(w2);
	assign half = prior_q >> 1;

	// Classify the strip against the threshold and the slope.
	assign below     = amp <= thr_q;
	assign has_open  = cnt_q != '0;
	assign rising_ok = w2 >= prior_q;
	assign split     = !below && has_open && rising_ok && fall_q && (pos_q != '0);
	assign last      = frame_end || (pos_q == POS_W'(MAX_STRIPS - 1));
	assign ser_base  = kind_q ? upper_q : lower_q;

	// Cluster that stays open after this strip.
	always_comb begin
		if (below) begin
			n_cnt = '0;
			n_w   = '0;
			n_s1  = '0;
			n_s2  = '0;
		end else if (split) begin
			n_cnt = CNT_W'(2);
			n_w   = W_W'(half) + W_W'(w2);
			n_s1  = S1_W'(p1_q >> 1) + S1_W'(m1);
			n_s2  = S2_W'(p2_q >> 1) + S2_W'(m2);
		end else begin
			n_cnt = cnt_q + CNT_W'(1);
			n_w   = w_q + W_W'(w2);
			n_s1  = s1_q + S1_W'(m1);
			n_s2  = s2_q + S2_W'(m2);
		end
	end

	assign emit0 = below ? has_open : split;
	assign emit1 = last && (n_cnt != '0);

	// Closed cluster records; the split one gives back half of the valley.
	always_comb begin
		rec0.weight = split ? w_q - W_W'(half) : w_q;
		rec0.s1     = split ? s1_q - S1_W'(p1_q >> 1) : s1_q;
		rec0.s2     = split ? s2_q - S2_W'(p2_q >> 1) : s2_q;
		rec0.count  = cnt_q;
		rec0.size   = SIZE_W'(pos_q) + SIZE_W'(1);
		rec0.serial = ser_base;
		rec0.kind   = kind_q;
		rec0.last   = !emit1;
		rec1.weight = n_w;
		rec1.s1     = n_s1;
		rec1.s2     = n_s2;
		rec1.count  = n_cnt;
		rec1.size   = SIZE_W'(pos_q) + SIZE_W'(1);
		rec1.serial = ser_base + SER_W'(emit0);
		rec1.kind   = kind_q;
		rec1.last   = 1'b1;
	end

	// Queue write: a held second record goes first.
	always_comb begin
		if (pend_q) begin
			push     = 1'b1;
			push_rec = pend_rec_q;
		end else begin
			push     = accept && (emit0 || emit1);
			push_rec = emit0 ? rec0 : rec1;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			kind_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD:  thr_q  <= cfg_data[AMP_BITS-1:0];
				CFG_LAYER_KIND: kind_q <= cfg_data[0];
				default:        thr_q  <= thr_q;
			endcase
		end
	end

	// Held second record when a strip closes two clusters.
	always_ff @(posedge clk) begin
		if (accept && emit0 && emit1) begin
			pend_rec_q <= rec1;
		end
	end

	// Frame and cluster state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			pos_q   <= '0;
			sq_q    <= '0;
			prior_q <= '0;
			p1_q    <= '0;
			p2_q    <= '0;
			fall_q  <= 1'b0;
			cnt_q   <= '0;
			w_q     <= '0;
			s1_q    <= '0;
			s2_q    <= '0;
			lower_q <= '0;
			upper_q <= '0;
		end else if (pend_q) begin
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= emit0 && emit1;
			if (kind_q) begin
				upper_q <= upper_q + SER_W'(emit0) + SER_W'(emit1);
			end else begin
				lower_q <= lower_q + SER_W'(emit0) + SER_W'(emit1);
			end
			if (last) begin
				pos_q   <= '0;
				sq_q    <= '0;
				prior_q <= '0;
				fall_q  <= 1'b0;
				cnt_q   <= '0;
				w_q     <= '0;
				s1_q    <= '0;
				s2_q    <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				sq_q  <= sq_q + SQ_W'({pos_q, 1'b0}) + SQ_W'(1);
				cnt_q <= n_cnt;
				w_q   <= n_w;
				s1_q  <= n_s1;
				s2_q  <= n_s2;
				if (below) begin
					fall_q <= 1'b0;
				end else begin
					prior_q <= w2;
					p1_q    <= m1;
					p2_q    <= m2;
					fall_q  <= has_open && !rising_ok;
				end
			end
		end
	end

	`SFC_ASSERT(a_pend_pushes, clk, arst_n, pend_q |-> (push && !in_ready))
	`SFC_ASSERT(a_two_closes_hold, clk, arst_n, (accept && emit0 && emit1) |=> pend_q)

endmodule

FILE: design/sfc_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfc_queue #(
	parameter int DEPTH = sfc_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sfc_pkg::cluster_rec_t push_rec,
	input  logic                  pop,
	output sfc_pkg::cluster_rec_t pop_rec,
	output sfc_pkg::queue_stat_t  stat
);
	import sfc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	cluster_rec_t      mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [FILL_W-1:0] fill_q;

	assign pop_rec        = mem_q[rd_q];
	assign stat.not_empty = fill_q != '0;
	assign stat.room2     = fill_q <= FILL_W'(DEPTH - 2);

	// Record storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			fill_q <= fill_q + FILL_W'(push) - FILL_W'(pop);
		end
	end

	`SFC_NEVER(a_no_overflow, clk, arst_n, push && !pop && (fill_q == FILL_W'(DEPTH)))
	`SFC_NEVER(a_no_underflow, clk, arst_n, pop && (fill_q == '0))

endmodule

FILE: design/sfc_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sfc_pkg::queue_stat_t         qstat,
	input  sfc_pkg::cluster_rec_t        rec,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sfc_pkg::CEN_W-1:0]    centroid,
	output logic [sfc_pkg::W_W-1:0]      total,
	output logic [sfc_pkg::SPR_W-1:0]    spread,
	output logic [sfc_pkg::CNT_W-1:0]    count,
	output logic [sfc_pkg::SER_W-1:0]    serial,
	output logic                         kind,
	output logic                         run_last
);
	import sfc_pkg::*;

	back_state_t         st_q, st_nx;
	cluster_rec_t        rec_q;
	logic [DIV_W-1:0]    n_q, q_q;
	logic [W_W-1:0]      r_q;
	logic [STEP_W-1:0]   k_q;
	logic [PROD_W-1:0]   mc_q, acc_q, a_q;
	logic [ML_W-1:0]     ml_q;
	logic [CEN_W-1:0]    cen_q;
	logic [SPR_W-1:0]    spr_q;

	logic                step_end, ge, multi;
	logic [W_W:0]        rem_sh;
	logic [W_W-1:0]      rem_nx;
	logic [DIV_W-1:0]    q_nx;
	logic [PROD_W-1:0]   acc_nx;
	logic [CEN_NUM_W-1:0] cen_num;
	logic [CEN_FULL_W-1:0] size_full, size_m1;

	// One restoring divide step by the cluster weight.
	assign rem_sh = {r_q, n_q[DIV_W-1]};
	assign ge     = rem_sh >= {1'b0, rec_q.weight};
	assign rem_nx = ge ? W_W'(rem_sh - {1'b0, rec_q.weight}) : rem_sh[W_W-1:0];
	assign q_nx   = {q_q[DIV_W-2:0], ge};

	// One shift-and-add multiply step.
	assign acc_nx = ml_q[0] ? acc_q + mc_q : acc_q;

	assign step_end  = k_q == STEP_W'(1);
	assign multi     = (rec_q.count > CNT_W'(1)) && (rec_q.weight != '0);
	assign cen_num   = CEN_NUM_W'({rec.s1, {FRAC_BITS{1'b0}}}) +
		CEN_NUM_W'({rec.weight, {(FRAC_BITS - 1){1'b0}}});
	assign size_full = {rec_q.size, {FRAC_BITS{1'b0}}};
	assign size_m1   = size_full - CEN_FULL_W'(1);

	// Sequencer next state.
	always_comb begin
		st_nx = st_q;
		pop   = 1'b0;
		unique case (st_q)
			BK_IDLE: begin
				if (qstat.not_empty) begin
					pop   = 1'b1;
					st_nx = BK_CEN;
				end
			end
			BK_CEN:   if (step_end) st_nx = multi ? BK_MUL_A : BK_OUT;
			BK_MUL_A: if (step_end) st_nx = BK_MUL_B;
			BK_MUL_B: if (step_end) st_nx = BK_DIFF;
			BK_DIFF:  st_nx = (a_q < acc_q) ? BK_OUT : BK_DIV1;
			BK_DIV1:  if (step_end) st_nx = BK_DIV2;
			BK_DIV2:  if (step_end) st_nx = BK_OUT;
			BK_OUT:   if (out_ready) st_nx = BK_IDLE;
			default:  st_nx = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	// Divider, multiplier and result registers.
	always_ff @(posedge clk) begin
		case (st_q)
			BK_IDLE: begin
				rec_q <= rec;
				n_q   <= {cen_num, {(DIV_W - CEN_NUM_W){1'b0}}};
				q_q   <= '0;
				r_q   <= '0;
				k_q   <= STEP_W'(CEN_NUM_W);
			end
			BK_CEN: begin
				n_q <= n_q << 1;
				q_q <= q_nx;
				r_q <= rem_nx;
				if (step_end) begin
					if (rec_q.weight == '0) begin
						cen_q <= '0;
					end else if (q_nx >= DIV_W'(size_full)) begin
						cen_q <= size_m1[CEN_W-1:0];
					end else begin
						cen_q <= q_nx[CEN_W-1:0];
					end
					spr_q <= SPREAD_SINGLE[SPR_W-1:0];
					acc_q <= '0;
					mc_q  <= PROD_W'(rec_q.s2);
					ml_q  <= ML_W'(rec_q.weight);
					k_q   <= STEP_W'(W_W);
				end else begin
					k_q <= k_q - STEP_W'(1);
				end
			end
			BK_MUL_A: begin
				if (step_end) begin
					a_q   <= acc_nx;
					acc_q <= '0;
					mc_q  <= PROD_W'(rec_q.s1);
					ml_q  <= ML_W'(rec_q.s1);
					k_q   <= STEP_W'(S1_W);
				end else begin
					acc_q <= acc_nx;
					mc_q  <= mc_q << 1;
					ml_q  <= ml_q >> 1;
					k_q   <= k_q - STEP_W'(1);
				end
			end
			BK_MUL_B: begin
				acc_q <= acc_nx;
				mc_q  <= mc_q << 1;
				ml_q  <= ml_q >> 1;
				k_q   <= k_q - STEP_W'(1);
			end
			BK_DIFF: begin
				spr_q <= '0;
				n_q   <= {a_q - acc_q, {FRAC_BITS{1'b0}}};
				q_q   <= '0;
				r_q   <= '0;
				k_q   <= STEP_W'(DIV_W);
			end
			BK_DIV1: begin
				if (step_end) begin
					n_q <= q_nx;
					q_q <= '0;
					r_q <= '0;
					k_q <= STEP_W'(DIV_W);
				end else begin
					n_q <= n_q << 1;
					q_q <= q_nx;
					r_q <= rem_nx;
					k_q <= k_q - STEP_W'(1);
				end
			end
			BK_DIV2: begin
				n_q <= n_q << 1;
				q_q <= q_nx;
				r_q <= rem_nx;
				k_q <= k_q - STEP_W'(1);
				if (step_end) begin
					spr_q <= q_nx[SPR_W-1:0];
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign out_valid = st_q == BK_OUT;
	assign centroid  = cen_q;
	assign total     = rec_q.weight;
	assign spread    = spr_q;
	assign count     = rec_q.count;
	assign serial    = rec_q.serial;
	assign kind      = rec_q.kind;
	assign run_last  = rec_q.last;

	`SFC_ASSERT(a_pop_starts, clk, arst_n, pop |=> (st_q == BK_CEN))
	`SFC_ASSERT(a_out_holds, clk, arst_n, (out_valid && !out_ready) |=> out_valid)

endmodule

FILE: design/strip_cluster_finder_top.sv
`timescale 1ns / 1ps
// Strips are taken one per cycle while the queue has room for two records and no record is held;
// a strip that closes two clusters holds input while its second record is written. In the back end
// each cluster is worked off by the bit-serial shift-add multiplier and the one-bit-per-cycle divider
// that centroid and spread share; a cluster of one strip skips the multiply and the spread divide.
// A four-entry record queue lets the front keep taking strips while clusters are worked off.
// arst_n clears thresholds, serial counters, frame state, queue and sequencer at once.
module strip_cluster_finder_top #(
	parameter int QUEUE_DEPTH = sfc_pkg::QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  sfc_pkg::cfg_reg_t         cfg_index,
	input  logic [sfc_pkg::CFG_W-1:0] cfg_data,
	strip_in_if.sink                  strip_in,
	cluster_out_if.source             cluster_out
);
	import sfc_pkg::*;

	logic         push, pop;
	cluster_rec_t push_rec, pop_rec;
	queue_stat_t  qstat;

	sfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (strip_in.valid),
		.in_ready  (strip_in.ready),
		.amp       (strip_in.strip_amplitude),
		.frame_end (strip_in.frame_end),
		.qstat     (qstat),
		.push      (push),
		.push_rec  (push_rec)
	);

	sfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.stat     (qstat)
	);

	sfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.rec       (pop_rec),
		.pop       (pop),
		.out_valid (cluster_out.valid),
		.out_ready (cluster_out.ready),
		.centroid  (cluster_out.centroid_q8),
		.total     (cluster_out.total_half_units),
		.spread    (cluster_out.spread_q8),
		.count     (cluster_out.member_count),
		.serial    (cluster_out.cluster_serial),
		.kind      (cluster_out.cluster_kind),
		.run_last  (cluster_out.run_last)
	);

endmodule
